[rtl/ccw_pkg.sv]
// Package: calendar clock types, constants and month length lookup.
`timescale 1ns / 1ps
`default_nettype none
package ccw_pkg;

  localparam int unsigned MonthW   = 4;
  localparam int unsigned DateW    = 5;
  localparam int unsigned YearW    = 7;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned HoursW   = 5;
  localparam int unsigned MinutesW = 6;
  localparam int unsigned SecondsW = 6;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [SecondsW-1:0] SecLast  = SecondsW'(59);
  localparam logic [MinutesW-1:0] MinLast  = MinutesW'(59);
  localparam logic [HoursW-1:0]   HourLast = HoursW'(23);
  localparam logic [WeekdayW-1:0] WdLast   = WeekdayW'(6);
  localparam logic [WeekdayW-1:0] WdSunday = WeekdayW'(0);
  localparam logic [MonthW-1:0]   MonLast  = MonthW'(12);
  localparam logic [YearW-1:0]    YearLast = YearW'(98);
  localparam logic [MonthW-1:0]   MonFeb   = MonthW'(2);
  localparam logic [MonthW-1:0]   MonApr   = MonthW'(4);
  localparam logic [MonthW-1:0]   MonJun   = MonthW'(6);
  localparam logic [MonthW-1:0]   MonSep   = MonthW'(9);
  localparam logic [MonthW-1:0]   MonNov   = MonthW'(11);
  localparam logic [DateW-1:0]    Days28   = DateW'(28);
  localparam logic [DateW-1:0]    Days29   = DateW'(29);
  localparam logic [DateW-1:0]    Days30   = DateW'(30);
  localparam logic [DateW-1:0]    Days31   = DateW'(31);

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_HOUR   = 2'd0,
    REG_START_MINUTE = 2'd1,
    REG_END_HOUR     = 2'd2,
    REG_END_MINUTE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SecondsW-1:0] seconds;
    logic [MinutesW-1:0] minutes;
    logic [HoursW-1:0]   hours;
    logic [WeekdayW-1:0] weekday;
    logic [YearW-1:0]    year;
    logic [DateW-1:0]    date;
    logic [MonthW-1:0]   month;
  } cal_time_t;

  function automatic logic [DateW-1:0] month_length(
    input logic [MonthW-1:0] month,
    input logic [YearW-1:0]  year
  );
    logic [DateW-1:0] len;
    case (month)
      MonFeb:                         len = (year[1:0] == 2'b00) ? Days29 : Days28;
      MonApr, MonJun, MonSep, MonNov: len = Days30;
      default:                        len = Days31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[rtl/calendar_clock_with_window.sv]
// Calendar clock with weekday collection window: top level.
// The result of an accepted item is in the output register in the next cycle.
// Throughput: one item per cycle; the seconds-to-year carry chain and the window
// compare sit between the clock registers and the output register.
// The next item is taken while a result waits, as long as the output is taken too.
// Reset: synchronous; time 00:00:00 weekday 0, date 1, month 1, year 0, unset;
// window registers cleared, output empty.
`timescale 1ns / 1ps
`default_nettype none
module calendar_clock_with_window (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ccw_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [ccw_pkg::CfgDataW-1:0]   cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // load_month, load_date, load_year, load_weekday, load_hours, load_minutes,
  // load_seconds, zero fill
  input  wire logic [ccw_pkg::InDataW-1:0]    s_tdata,
  // command
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // cur_month, cur_date, cur_year, cur_weekday, cur_hours, cur_minutes,
  // cur_seconds, in_window, zero fill
  output logic [ccw_pkg::OutDataW-1:0]        m_tdata,
  // clock_valid
  output logic                                m_tuser
);

  localparam int unsigned TimeW = $bits(ccw_pkg::cal_time_t);

  logic [ccw_pkg::HoursW-1:0]   start_hour;
  logic [ccw_pkg::MinutesW-1:0] start_minute;
  logic [ccw_pkg::HoursW-1:0]   end_hour;
  logic [ccw_pkg::MinutesW-1:0] end_minute;

  ccw_pkg::cal_time_t tm;
  ccw_pkg::cal_time_t tm_next;
  ccw_pkg::cal_time_t load_tm;
  logic               loaded;
  logic               loaded_next;
  logic               win_next;
  logic               accept;
  ccw_pkg::cmd_t      cmd;
  logic [ccw_pkg::DateW-1:0] mlen;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = ccw_pkg::cmd_t'(s_tuser);
  assign load_tm  = ccw_pkg::cal_time_t'(s_tdata[TimeW-1:0]);
  assign mlen     = ccw_pkg::month_length(tm.month, tm.year);

  always_comb begin
    tm_next     = tm;
    loaded_next = loaded;
    if (cmd == ccw_pkg::CMD_LOAD) begin
      tm_next     = load_tm;
      loaded_next = 1'b1;
    end else if (loaded) begin
      if (tm.seconds < ccw_pkg::SecLast) begin
        tm_next.seconds = tm.seconds + 1'b1;
      end else begin
        tm_next.seconds = '0;
        if (tm.minutes < ccw_pkg::MinLast) begin
          tm_next.minutes = tm.minutes + 1'b1;
        end else begin
          tm_next.minutes = '0;
          if (tm.hours < ccw_pkg::HourLast) begin
            tm_next.hours = tm.hours + 1'b1;
          end else begin
            tm_next.hours   = '0;
            tm_next.weekday = (tm.weekday >= ccw_pkg::WdLast) ? '0 : tm.weekday + 1'b1;
            if (tm.date < mlen) begin
              tm_next.date = tm.date + 1'b1;
            end else begin
              tm_next.date = ccw_pkg::DateW'(1);
              if (tm.month < ccw_pkg::MonLast) begin
                tm_next.month = tm.month + 1'b1;
              end else begin
                tm_next.month = ccw_pkg::MonthW'(1);
                tm_next.year  = (tm.year >= ccw_pkg::YearLast) ? '0 : tm.year + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    win_next = 1'b0;
    if (!loaded_next) begin
      win_next = 1'b0;
    end else if (tm_next.weekday == ccw_pkg::WdSunday || tm_next.weekday == ccw_pkg::WdLast) begin
      win_next = 1'b0;
    end else if (tm_next.hours > start_hour && tm_next.hours < end_hour) begin
      win_next = 1'b1;
    end else if (start_hour == end_hour &&
                 (tm_next.minutes < start_minute || tm_next.minutes >= end_minute)) begin
      win_next = 1'b0;
    end else if ((tm_next.hours == start_hour && tm_next.minutes >= start_minute) ||
                 (tm_next.hours == end_hour && tm_next.minutes < end_minute)) begin
      win_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_hour   <= '0;
      start_minute <= '0;
      end_hour     <= '0;
      end_minute   <= '0;
    end else if (cfg_we) begin
      unique case (ccw_pkg::cfg_reg_t'(cfg_index))
        ccw_pkg::REG_START_HOUR:   start_hour   <= cfg_data[ccw_pkg::HoursW-1:0];
        ccw_pkg::REG_START_MINUTE: start_minute <= cfg_data;
        ccw_pkg::REG_END_HOUR:     end_hour     <= cfg_data[ccw_pkg::HoursW-1:0];
        ccw_pkg::REG_END_MINUTE:   end_minute   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= 1'b0;
      tm.seconds <= '0;
      tm.minutes <= '0;
      tm.hours   <= '0;
      tm.weekday <= '0;
      tm.date    <= ccw_pkg::DateW'(1);
      tm.month   <= ccw_pkg::MonthW'(1);
      tm.year    <= '0;
      m_tvalid   <= 1'b0;
    end else if (accept) begin
      loaded   <= loaded_next;
      tm       <= tm_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(ccw_pkg::OutDataW - TimeW - 1){1'b0}}, win_next, tm_next};
      m_tuser <= loaded_next;
    end
  end

endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for the calendar clock with weekday window: stimulus, prediction and checks.
`timescale 1ns / 1ps
module testbench;

  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 145;
  localparam int NumPhases  = 7;

  typedef struct packed {
    ccw_pkg::cmd_t      cmd;
    ccw_pkg::cal_time_t t;
  } clock_cmd_t;

  typedef struct packed {
    logic               set;
    logic               in_win;
    ccw_pkg::cal_time_t t;
  } clock_reading_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_we    = 1'b0;
  logic [ccw_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [ccw_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [ccw_pkg::InDataW-1:0]  s_tdata   = '0;
  logic                         s_tuser   = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [ccw_pkg::OutDataW-1:0] m_tdata;
  logic                         m_tuser;

  clock_cmd_t     cmds_pending[$];
  clock_reading_t readings_due[$];
  clock_cmd_t     drive_cmd;
  clock_reading_t got_reading;
  clock_reading_t want_reading;

  // predicted clock and window registers
  ccw_pkg::cal_time_t now_time;
  logic               clock_set;
  logic [4:0]         win_sh, win_eh;
  logic [5:0]         win_sm, win_em;

  int   mismatches   = 0;
  int   quiet_cycles = 0;
  logic item_taken   = 1'b0;
  int   burst_left   = 1;
  int   gap_left     = 0;
  int   rx_cycle     = 0;
  int   hold_left    = 0;
  logic hold_request = 1'b0;
  logic hold_seen    = 1'b0;

  calendar_clock_with_window dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [4:0] days_in_month(logic [3:0] mon, logic [6:0] yr);
    logic [4:0] days;
    case (mon)
      4'd2:                  days = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:               days = 5'd31;
    endcase
    return days;
  endfunction

  function automatic ccw_pkg::cal_time_t next_second(ccw_pkg::cal_time_t t);
    ccw_pkg::cal_time_t n;
    n = t;
    if (n.seconds < 6'd59) begin
      n.seconds = n.seconds + 1'b1;
    end else begin
      n.seconds = '0;
      if (n.minutes < 6'd59) begin
        n.minutes = n.minutes + 1'b1;
      end else begin
        n.minutes = '0;
        if (n.hours < 5'd23) begin
          n.hours = n.hours + 1'b1;
        end else begin
          n.hours   = '0;
          n.weekday = (n.weekday >= 3'd6) ? 3'd0 : n.weekday + 1'b1;
          if (n.date < days_in_month(n.month, n.year)) begin
            n.date = n.date + 1'b1;
          end else begin
            n.date = 5'd1;
            if (n.month < 4'd12) begin
              n.month = n.month + 1'b1;
            end else begin
              n.month = 4'd1;
              n.year  = (n.year >= 7'd98) ? 7'd0 : n.year + 1'b1;
            end
          end
        end
      end
    end
    return n;
  endfunction

  function automatic logic window_open();
    if (!clock_set) return 1'b0;
    if (now_time.weekday == 3'd0 || now_time.weekday == 3'd6) return 1'b0;
    if (now_time.hours > win_sh && now_time.hours < win_eh) return 1'b1;
    if (win_sh == win_eh && (now_time.minutes < win_sm || now_time.minutes >= win_em))
      return 1'b0;
    return (now_time.hours == win_sh && now_time.minutes >= win_sm) ||
           (now_time.hours == win_eh && now_time.minutes < win_em);
  endfunction

  function automatic ccw_pkg::cal_time_t make_time(int mon, int date, int yr, int wd,
                                                   int hh, int mm, int ss);
    ccw_pkg::cal_time_t t;
    t.month   = 4'(mon);
    t.date    = 5'(date);
    t.year    = 7'(yr);
    t.weekday = 3'(wd);
    t.hours   = 5'(hh);
    t.minutes = 6'(mm);
    t.seconds = 6'(ss);
    return t;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_load(ccw_pkg::cal_time_t t);
    clock_cmd_t c;
    c.cmd = ccw_pkg::CMD_LOAD;
    c.t   = t;
    cmds_pending.push_back(c);
  endtask

  task automatic add_ticks(int n);
    clock_cmd_t c;
    repeat (n) begin
      c.cmd = ccw_pkg::CMD_TICK;
      c.t   = ccw_pkg::cal_time_t'(36'({$urandom, $urandom}));
      cmds_pending.push_back(c);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (cmds_pending.size() > 0) begin
        drive_cmd = cmds_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= drive_cmd.cmd;
        s_tdata  <= {4'b0, drive_cmd.t};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_seen != hold_request) begin
        hold_seen <= hold_request;
        hold_left <= 48;
        m_tready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_cycle[7:6])
          2'd0:    m_tready <= 1'b1;
          2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
          2'd2:    m_tready <= rx_cycle[0];
          default: m_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    item_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (ccw_pkg::cmd_t'(s_tuser) == ccw_pkg::CMD_LOAD) begin
          now_time  = s_tdata[35:0];
          clock_set = 1'b1;
        end else if (clock_set) begin
          now_time = next_second(now_time);
        end
        want_reading.set    = clock_set;
        want_reading.in_win = window_open();
        want_reading.t      = now_time;
        readings_due.push_back(want_reading);
      end
      if (m_tvalid && m_tready) begin
        got_reading.set    = m_tuser;
        got_reading.in_win = m_tdata[36];
        got_reading.t      = m_tdata[35:0];
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected result, count", 1, 0);
        end else begin
          want_reading = readings_due.pop_front();
          if (got_reading.set !== want_reading.set)
            report_mismatch("clock_valid", got_reading.set, want_reading.set);
          if (got_reading.t.month !== want_reading.t.month)
            report_mismatch("cur_month", got_reading.t.month, want_reading.t.month);
          if (got_reading.t.date !== want_reading.t.date)
            report_mismatch("cur_date", got_reading.t.date, want_reading.t.date);
          if (got_reading.t.year !== want_reading.t.year)
            report_mismatch("cur_year", got_reading.t.year, want_reading.t.year);
          if (got_reading.t.weekday !== want_reading.t.weekday)
            report_mismatch("cur_weekday", got_reading.t.weekday, want_reading.t.weekday);
          if (got_reading.t.hours !== want_reading.t.hours)
            report_mismatch("cur_hours", got_reading.t.hours, want_reading.t.hours);
          if (got_reading.t.minutes !== want_reading.t.minutes)
            report_mismatch("cur_minutes", got_reading.t.minutes, want_reading.t.minutes);
          if (got_reading.t.seconds !== want_reading.t.seconds)
            report_mismatch("cur_seconds", got_reading.t.seconds, want_reading.t.seconds);
          if (got_reading.in_win !== want_reading.in_win)
            report_mismatch("in_window", got_reading.in_win, want_reading.in_win);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("[calendar_clock_with_window] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (cmds_pending.size() != 0 || readings_due.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(ccw_pkg::cfg_reg_t idx, logic [5:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ccw_pkg::REG_START_HOUR:   win_sh = val[4:0];
      ccw_pkg::REG_START_MINUTE: win_sm = val;
      ccw_pkg::REG_END_HOUR:     win_eh = val[4:0];
      default:                   win_em = val;
    endcase
  endtask

  task automatic set_window(int sh, int sm, int eh, int em);
    write_reg(ccw_pkg::REG_START_HOUR, 6'(sh));
    write_reg(ccw_pkg::REG_START_MINUTE, 6'(sm));
    write_reg(ccw_pkg::REG_END_HOUR, 6'(eh));
    write_reg(ccw_pkg::REG_END_MINUTE, 6'(em));
  endtask

  task automatic queue_phase(int n_items);
    int                 queued;
    int                 kind;
    int                 mon, yr, hh, mm;
    ccw_pkg::cal_time_t t;
    queued = 0;
    while (queued < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        t = ccw_pkg::cal_time_t'(36'({$urandom, $urandom}));
      end else if (kind <= 3) begin
        mon = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
        yr  = ($urandom_range(0, 3) == 0) ? 98 : $urandom_range(0, 98);
        t   = make_time(mon, days_in_month(4'(mon), 7'(yr)) - $urandom_range(0, 1), yr,
                        $urandom_range(0, 7), 23, 59, $urandom_range(57, 59));
      end else if (kind <= 6) begin
        hh = ($urandom_range(0, 1) == 0) ? win_sh : win_eh;
        hh = (hh + $urandom_range(0, 2) + 31) % 32;
        mm = ($urandom_range(0, 1) == 0) ? win_sm : win_em;
        mm = (mm + 63 - $urandom_range(0, 1)) % 64;
        t  = make_time($urandom_range(1, 12), $urandom_range(1, 28), $urandom_range(0, 98),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5),
                       hh, mm, $urandom_range(58, 59));
      end else begin
        mon = $urandom_range(1, 12);
        yr  = $urandom_range(0, 98);
        t   = make_time(mon, $urandom_range(1, days_in_month(4'(mon), 7'(yr))), yr,
                        $urandom_range(0, 6), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
      end
      add_load(t);
      kind = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      add_ticks(kind);
      queued += kind + 1;
    end
  endtask

  int phase_cfg [NumPhases][4] = '{
    '{9, 0, 17, 30},
    '{23, 59, 23, 59},
    '{63, 63, 63, 63},
    '{8, 15, 8, 45},
    '{20, 0, 6, 0},
    '{0, 0, 23, 59},
    '{0, 0, 0, 0}
  };

  initial begin
    now_time  = make_time(1, 1, 0, 0, 0, 0, 0);
    clock_set = 1'b0;
    win_sh = '0; win_sm = '0; win_eh = '0; win_em = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ticks while unset, field extremes, calendar roll-overs
    add_ticks(2);
    add_load(make_time(15, 31, 127, 7, 31, 63, 63));
    add_ticks(1);
    add_load(make_time(0, 0, 0, 0, 0, 0, 0));
    add_ticks(1);
    add_load(make_time(12, 31, 98, 6, 23, 59, 59));
    add_ticks(1);
    add_load(make_time(2, 28, 4, 2, 23, 59, 59));
    add_ticks(1);
    add_load(make_time(2, 29, 4, 3, 23, 59, 59));
    add_ticks(1);
    add_load(make_time(2, 28, 5, 1, 23, 59, 59));
    add_ticks(1);
    add_load(make_time(4, 30, 10, 5, 23, 59, 59));
    add_ticks(1);
    add_load(make_time(6, 15, 20, 3, 0, 0, 59));
    add_ticks(1);
    add_load(make_time(1, 1, 0, 0, 12, 0, 0));
    add_ticks(1);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1)
        set_window($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
      else
        set_window(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      queue_phase(PhaseItems);
      if (p == 0) hold_request = ~hold_request;
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("[calendar_clock_with_window] OK");
    else
      $display("[calendar_clock_with_window] ERROR");
    $finish;
  end

endmodule
